// ===== hdl/gclc_pkg.sv =====
// Package for the G-code line classifier.
// Holds the character codes, phase codes and the result record shared by the RTL files.
// Depends on nothing.
`default_nettype none

package gclc_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_PAREN = 8'h28;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_Y = 8'h59;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [7:0] CH_LE = 8'h65;

  localparam logic [1:0] MP_LEAD = 2'd0;
  localparam logic [1:0] MP_RUN = 2'd1;
  localparam logic [1:0] MP_DONE = 2'd2;

  localparam logic [2:0] WP_LEAD = 3'd0;
  localparam logic [2:0] WP_DIGITS = 3'd1;
  localparam logic [2:0] WP_SCAN = 3'd2;
  localparam logic [2:0] WP_AFTER = 3'd3;
  localparam logic [2:0] WP_NUMBER = 3'd4;
  localparam logic [2:0] WP_DEAD = 3'd5;

  typedef struct packed {
    logic line_filtered;
    logic macro_command;
    logic word_missing_value;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/gclc_core.sv =====
// Per-line state and next-state logic of the G-code line classifier.
// Consumes one byte per step and reports a verdict when the line closes.
// Depends on gclc_pkg.
`default_nettype none

module gclc_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         text_byte,
  input  wire logic               end_of_text,
  output logic                    closes,
  output gclc_pkg::result_t       result
);

  logic [1:0] macro_phase;
  logic [1:0] macro_run_length;
  logic       macro_verdict;
  logic [2:0] word_phase;
  logic       word_missing_flag;
  logic       comment_reached;

  logic [1:0] mp_f;
  logic [1:0] ml_f;
  logic       mv_f;
  logic [2:0] wp_f;
  logic       wf_f;
  logic       cr_f;

  logic       is_nl;
  logic       is_blank;
  logic       is_digit;
  logic       is_upper;
  logic       is_letter;
  logic       is_vstart;
  logic       check;

  logic [1:0] mp_c;
  logic [1:0] ml_c;
  logic       mv_c;
  logic [2:0] wp_c;
  logic       wf_c;
  logic       cr_c;
  logic       macro_res;
  logic       word_res;

  always_comb begin
    is_nl = (text_byte == gclc_pkg::CH_NEWLINE);
    is_blank = (text_byte == gclc_pkg::CH_SPACE) || (text_byte == gclc_pkg::CH_TAB);
    is_digit = (text_byte >= gclc_pkg::CH_0) && (text_byte <= gclc_pkg::CH_9);
    is_upper = (text_byte >= gclc_pkg::CH_UA) && (text_byte <= gclc_pkg::CH_UZ);
    is_letter = (text_byte == gclc_pkg::CH_E) || (text_byte == gclc_pkg::CH_X) ||
                (text_byte == gclc_pkg::CH_Y) || (text_byte == gclc_pkg::CH_Z) ||
                (text_byte == gclc_pkg::CH_F) || (text_byte == gclc_pkg::CH_S) ||
                (text_byte == gclc_pkg::CH_P) || (text_byte == gclc_pkg::CH_R) ||
                (text_byte == gclc_pkg::CH_T);
    is_vstart = is_digit || (text_byte == gclc_pkg::CH_DOT) ||
                (text_byte == gclc_pkg::CH_MINUS) || (text_byte == gclc_pkg::CH_PLUS);
  end

  always_comb begin
    mp_f = macro_phase;
    ml_f = macro_run_length;
    mv_f = macro_verdict;
    if (macro_phase == gclc_pkg::MP_LEAD) begin
      if (!is_blank) begin
        if (is_upper) begin
          mp_f = gclc_pkg::MP_RUN;
          ml_f = 2'd1;
        end else begin
          mp_f = gclc_pkg::MP_DONE;
          mv_f = 1'b0;
        end
      end
    end else if (macro_phase == gclc_pkg::MP_RUN) begin
      if (is_upper || (text_byte == gclc_pkg::CH_UNDER)) begin
        if (macro_run_length < 2'd2) begin
          ml_f = macro_run_length + 2'd1;
        end
      end else begin
        mv_f = (macro_run_length >= 2'd2) &&
               (is_blank || (text_byte == gclc_pkg::CH_CR) ||
                (text_byte == gclc_pkg::CH_EQUAL));
        mp_f = gclc_pkg::MP_DONE;
      end
    end
  end

  always_comb begin
    wp_f = word_phase;
    wf_f = word_missing_flag;
    cr_f = comment_reached;
    check = 1'b0;
    if (!comment_reached) begin
      if ((text_byte == gclc_pkg::CH_SEMI) || (text_byte == gclc_pkg::CH_PAREN)) begin
        if (word_phase == gclc_pkg::WP_AFTER) begin
          wf_f = 1'b1;
        end
        cr_f = 1'b1;
      end else begin
        unique case (word_phase)
          gclc_pkg::WP_LEAD: begin
            if (!is_blank) begin
              wp_f = ((text_byte == gclc_pkg::CH_M) || (text_byte == gclc_pkg::CH_G)) ?
                     gclc_pkg::WP_DIGITS : gclc_pkg::WP_DEAD;
            end
          end
          gclc_pkg::WP_DIGITS: begin
            if (!is_digit) begin
              wp_f = gclc_pkg::WP_SCAN;
              check = 1'b1;
            end
          end
          gclc_pkg::WP_AFTER: begin
            if (is_vstart) begin
              wp_f = gclc_pkg::WP_NUMBER;
            end else begin
              wf_f = 1'b1;
              wp_f = gclc_pkg::WP_SCAN;
              check = 1'b1;
            end
          end
          gclc_pkg::WP_NUMBER: begin
            if (!(is_vstart || (text_byte == gclc_pkg::CH_E) ||
                  (text_byte == gclc_pkg::CH_LE))) begin
              wp_f = gclc_pkg::WP_SCAN;
              check = 1'b1;
            end
          end
          gclc_pkg::WP_SCAN: begin
            check = 1'b1;
          end
          default: begin
            check = 1'b0;
          end
        endcase
        if (check && is_letter) begin
          wp_f = gclc_pkg::WP_AFTER;
        end
      end
    end
  end

  always_comb begin
    mp_c = is_nl ? macro_phase : mp_f;
    ml_c = is_nl ? macro_run_length : ml_f;
    mv_c = is_nl ? macro_verdict : mv_f;
    wp_c = is_nl ? word_phase : wp_f;
    wf_c = is_nl ? word_missing_flag : wf_f;
    cr_c = is_nl ? comment_reached : cr_f;
    if (mp_c == gclc_pkg::MP_RUN) begin
      macro_res = (ml_c >= 2'd2);
    end else if (mp_c == gclc_pkg::MP_DONE) begin
      macro_res = mv_c;
    end else begin
      macro_res = 1'b0;
    end
    word_res = wf_c || (!cr_c && (wp_c == gclc_pkg::WP_AFTER));
    closes = is_nl || end_of_text;
    result.line_filtered = macro_res || word_res;
    result.macro_command = macro_res;
    result.word_missing_value = word_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && closes)) begin
      macro_phase <= gclc_pkg::MP_LEAD;
      macro_run_length <= 2'd0;
      macro_verdict <= 1'b0;
      word_phase <= gclc_pkg::WP_LEAD;
      word_missing_flag <= 1'b0;
      comment_reached <= 1'b0;
    end else if (step) begin
      macro_phase <= mp_f;
      macro_run_length <= ml_f;
      macro_verdict <= mv_f;
      word_phase <= wp_f;
      word_missing_flag <= wf_f;
      comment_reached <= cr_f;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gcode_line_filter_classifier.sv =====
// Top level of the G-code line classifier: input register, line logic, result register.
// Depends on gclc_pkg and gclc_core.
`default_nettype none

// Takes one text byte per cycle and gives one result per line, at the newline
// byte or at the byte marked as the end of the text. A byte is registered on
// transfer and runs through the line logic from that register; a closing byte
// loads its result into the result register when it steps and that register is
// free, and the line result is offered from the result register.
// The rate is one byte per cycle; the input only stalls when a closing byte is
// waiting and the result register holds a result that the receiver stalls.
module gcode_line_filter_classifier (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            line_filtered,
  output logic            macro_command,
  output logic            word_missing_value
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              held_end;
  logic              closes;
  logic              step;
  logic              out_free;
  gclc_pkg::result_t result;
  gclc_pkg::result_t result_reg;

  gclc_core u_core (
    .clk(clk),
    .rst(rst),
    .step(step),
    .text_byte(held_byte),
    .end_of_text(held_end),
    .closes(closes),
    .result(result)
  );

  assign out_free = !out_valid || !out_stall;
  assign step = held_valid && (!closes || out_free);
  assign in_stall = held_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= text_byte;
      held_end <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && closes;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && closes) begin
      result_reg <= result;
    end
  end

  assign line_filtered = result_reg.line_filtered;
  assign macro_command = result_reg.macro_command;
  assign word_missing_value = result_reg.word_missing_value;

endmodule

`default_nettype wire

// ===== hdl/gclc_checker.sv =====
// Port-level checks for the G-code line classifier, and the bind that attaches them.
// Depends on gcode_line_filter_classifier.
`default_nettype none

module gclc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic line_filtered,
  input wire logic macro_command,
  input wire logic word_missing_value
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_filtered) &&
    $stable(macro_command) && $stable(word_missing_value))
    else $error("Stalled result changed.");

  a_filter_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_filtered == (macro_command || word_missing_value))
    else $error("Filter flag is not the OR of the two tests.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the result register could take a transfer.");

endmodule

bind gcode_line_filter_classifier gclc_checker u_gclc_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .line_filtered(line_filtered),
  .macro_command(macro_command),
  .word_missing_value(word_missing_value)
);

`default_nettype wire

// ===== verif/tb_gcode_line_filter_classifier.sv =====
// Self-checking testbench for gcode_line_filter_classifier: drives G-code text bytes,
// predicts the per-line verdicts in a small scoreboard class and checks every result.
// Depends on gclc_pkg and the RTL of the classifier.

module tb_gcode_line_filter_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_BYTES = 1300;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT = 23;

  class line_scoreboard;
    gclc_pkg::result_t verdicts_due[$];
    int errors;
    logic [1:0] name_state;
    logic [1:0] name_len;
    logic name_hit;
    logic [2:0] word_state;
    logic bare_word;
    logic in_comment;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      name_state = gclc_pkg::MP_LEAD;
      name_len = 2'd0;
      name_hit = 1'b0;
      word_state = gclc_pkg::WP_LEAD;
      bare_word = 1'b0;
      in_comment = 1'b0;
    endfunction

    function void close_line();
      gclc_pkg::result_t verdict;
      logic macro;
      logic word;
      macro = 1'b0;
      if (name_state == gclc_pkg::MP_RUN) begin
        macro = (name_len >= 2'd2);
      end else if (name_state == gclc_pkg::MP_DONE) begin
        macro = name_hit;
      end
      word = bare_word | (!in_comment && word_state == gclc_pkg::WP_AFTER);
      verdict.line_filtered = macro | word;
      verdict.macro_command = macro;
      verdict.word_missing_value = word;
      verdicts_due.insert(verdicts_due.size(), verdict);
      clear_line();
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      logic blank;
      logic upper;
      logic digit;
      logic value_start;
      logic scan;
      blank = (c == gclc_pkg::CH_SPACE) || (c == gclc_pkg::CH_TAB);
      upper = (c >= gclc_pkg::CH_UA) && (c <= gclc_pkg::CH_UZ);
      digit = (c >= gclc_pkg::CH_0) && (c <= gclc_pkg::CH_9);
      value_start = digit || c == gclc_pkg::CH_DOT || c == gclc_pkg::CH_MINUS ||
                    c == gclc_pkg::CH_PLUS;
      if (c == gclc_pkg::CH_NEWLINE) begin
        close_line();
      end else begin
        case (name_state)
          gclc_pkg::MP_LEAD: begin
            if (!blank) begin
              if (upper) begin
                name_state = gclc_pkg::MP_RUN;
                name_len = 2'd1;
              end else begin
                name_state = gclc_pkg::MP_DONE;
                name_hit = 1'b0;
              end
            end
          end
          gclc_pkg::MP_RUN: begin
            if (upper || c == gclc_pkg::CH_UNDER) begin
              if (name_len < 2'd2) name_len = name_len + 2'd1;
            end else begin
              name_hit = (name_len >= 2'd2) &&
                         (blank || c == gclc_pkg::CH_CR || c == gclc_pkg::CH_EQUAL);
              name_state = gclc_pkg::MP_DONE;
            end
          end
          default: ;
        endcase
        if (!in_comment) begin
          if (c == gclc_pkg::CH_SEMI || c == gclc_pkg::CH_PAREN) begin
            if (word_state == gclc_pkg::WP_AFTER) bare_word = 1'b1;
            in_comment = 1'b1;
          end else begin
            scan = 1'b0;
            case (word_state)
              gclc_pkg::WP_LEAD: begin
                if (!blank) begin
                  word_state = (c == gclc_pkg::CH_M || c == gclc_pkg::CH_G) ?
                               gclc_pkg::WP_DIGITS : gclc_pkg::WP_DEAD;
                end
              end
              gclc_pkg::WP_DIGITS: begin
                if (!digit) begin
                  word_state = gclc_pkg::WP_SCAN;
                  scan = 1'b1;
                end
              end
              gclc_pkg::WP_AFTER: begin
                if (value_start) begin
                  word_state = gclc_pkg::WP_NUMBER;
                end else begin
                  bare_word = 1'b1;
                  word_state = gclc_pkg::WP_SCAN;
                  scan = 1'b1;
                end
              end
              gclc_pkg::WP_NUMBER: begin
                if (!(value_start || c == gclc_pkg::CH_E || c == gclc_pkg::CH_LE)) begin
                  word_state = gclc_pkg::WP_SCAN;
                  scan = 1'b1;
                end
              end
              gclc_pkg::WP_SCAN: scan = 1'b1;
              default: ;
            endcase
            if (scan && (c inside {gclc_pkg::CH_E, gclc_pkg::CH_X, gclc_pkg::CH_Y,
                                   gclc_pkg::CH_Z, gclc_pkg::CH_F, gclc_pkg::CH_S,
                                   gclc_pkg::CH_P, gclc_pkg::CH_R, gclc_pkg::CH_T}))
            begin
              word_state = gclc_pkg::WP_AFTER;
            end
          end
        end
        if (last) close_line();
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(gclc_pkg::result_t got);
      gclc_pkg::result_t want;
      if (verdicts_due.size() == 0) begin
        report("line result with no line closed");
      end else begin
        want = verdicts_due.pop_front();
        if (got.line_filtered !== want.line_filtered) begin
          report($sformatf("line_filtered %b, expected %b", got.line_filtered,
                           want.line_filtered));
        end
        if (got.macro_command !== want.macro_command) begin
          report($sformatf("macro_command %b, expected %b", got.macro_command,
                           want.macro_command));
        end
        if (got.word_missing_value !== want.word_missing_value) begin
          report($sformatf("word_missing_value %b, expected %b", got.word_missing_value,
                           want.word_missing_value));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] text_byte = 8'h00;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic line_filtered;
  logic macro_command;
  logic word_missing_value;

  line_scoreboard sb;
  logic [7:0] line_buf[$];
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  gcode_line_filter_classifier u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .line_filtered(line_filtered),
    .macro_command(macro_command),
    .word_missing_value(word_missing_value)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    gclc_pkg::result_t got;
    if (!rst) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        sb.note_byte(text_byte, end_of_text);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        got.line_filtered = line_filtered;
        got.macro_command = macro_command;
        got.word_missing_value = word_missing_value;
        sb.check_result(got);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // The receiver stalls at random, except for one long hold-off counted here; no_idle turns the random stalls off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  function automatic void add_char(logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], last && (i == s.len() - 1));
    end
  endtask

  task automatic make_line();
    logic [7:0] word_letters[9];
    logic [7:0] value_marks[5];
    int kind;
    word_letters = '{gclc_pkg::CH_E, gclc_pkg::CH_X, gclc_pkg::CH_Y, gclc_pkg::CH_Z,
                     gclc_pkg::CH_F, gclc_pkg::CH_S, gclc_pkg::CH_P, gclc_pkg::CH_R,
                     gclc_pkg::CH_T};
    value_marks = '{gclc_pkg::CH_DOT, gclc_pkg::CH_MINUS, gclc_pkg::CH_PLUS,
                    gclc_pkg::CH_LE, gclc_pkg::CH_E};
    line_buf.delete();
    kind = $urandom_range(9);
    repeat ($urandom_range(2)) add_char($urandom_range(1) ? gclc_pkg::CH_SPACE
                                                          : gclc_pkg::CH_TAB);
    if (kind < 5) begin
      add_char($urandom_range(1) ? gclc_pkg::CH_M : gclc_pkg::CH_G);
      repeat ($urandom_range(3)) add_char(8'(gclc_pkg::CH_0 + $urandom_range(9)));
      repeat ($urandom_range(5)) begin
        if ($urandom_range(2) == 0) add_char(gclc_pkg::CH_SPACE);
        if ($urandom_range(3) == 0) begin
          add_char($urandom_range(1) ? 8'(gclc_pkg::CH_UA + $urandom_range(25))
                                     : 8'(gclc_pkg::CH_LE + $urandom_range(20)));
        end else begin
          add_char(word_letters[$urandom_range(8)]);
        end
        repeat ($urandom_range(3)) begin
          add_char($urandom_range(1) ? 8'(gclc_pkg::CH_0 + $urandom_range(9))
                                     : value_marks[$urandom_range(4)]);
        end
      end
      if ($urandom_range(3) == 0) begin
        add_char($urandom_range(1) ? gclc_pkg::CH_SEMI : gclc_pkg::CH_PAREN);
        repeat ($urandom_range(3)) add_char(word_letters[$urandom_range(8)]);
      end
    end else if (kind < 8) begin
      repeat ($urandom_range(1, 4)) begin
        add_char($urandom_range(4) == 0 ? gclc_pkg::CH_UNDER
                                        : 8'(gclc_pkg::CH_UA + $urandom_range(25)));
      end
      case ($urandom_range(5))
        0: add_char(gclc_pkg::CH_SPACE);
        1: add_char(gclc_pkg::CH_CR);
        2: add_char(gclc_pkg::CH_EQUAL);
        3: add_char(gclc_pkg::CH_TAB);
        4: add_char(8'(gclc_pkg::CH_LE + $urandom_range(20)));
        default: ;
      endcase
      repeat ($urandom_range(3)) add_char(8'(gclc_pkg::CH_SPACE + $urandom_range(94)));
    end else begin
      repeat ($urandom_range(6)) add_char(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int sent;
    int ending;
    logic held;
    logic paused;
    sb = new();
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(gclc_pkg::CH_NEWLINE, 1'b0);
    send_text("\n", 1'b0);
    send_text("G1X\n", 1'b0);
    send_text("MX;\n", 1'b0);
    send_text("\tAB=\n", 1'b0);
    send_text("AB", 1'b1);
    send_text(" \n", 1'b1);

    while (sent < TEXT_BYTES) begin
      if (!held && sent >= 400) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && sent >= 800) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end
      no_idle = (sent >= 900) && (sent < 1150);
      make_line();
      ending = $urandom_range(19);
      if (ending != 0 || line_buf.size() == 0) add_char(gclc_pkg::CH_NEWLINE);
      foreach (line_buf[i]) begin
        send_byte(line_buf[i], (ending < 2) && (i == line_buf.size() - 1));
        sent++;
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== gcode_line_filter_classifier.f =====
hdl/gclc_pkg.sv
hdl/gclc_core.sv
hdl/gcode_line_filter_classifier.sv
hdl/gclc_checker.sv
verif/tb_gcode_line_filter_classifier.sv
